/* hdl/svs_pkg.sv */
package svs_pkg;

    localparam int MAX_NONZERO = 1024;
    localparam int CACHE_DEPTH = 32;
    localparam int COLUMN_BITS = 16;

    localparam int VAL_W   = 64;
    localparam int VLEN_W  = COLUMN_BITS + 1;
    localparam int CNT_W   = $clog2(MAX_NONZERO + 1);
    localparam int ADDR_W  = $clog2(MAX_NONZERO);
    localparam int FILL_W  = $clog2(CACHE_DEPTH + 1);
    localparam int CIDX_W  = $clog2(CACHE_DEPTH);
    localparam int ENTRY_W = COLUMN_BITS + VAL_W;
    localparam int SQ_W    = CNT_W + 2 * (FILL_W + 1);
    localparam int STAT_W  = 2;

    localparam logic [VAL_W-1:0] ABS_MASK = {1'b0, {(VAL_W - 1){1'b1}}};

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CS_RD,
        CMD_CS_CHK,
        CMD_SR_INIT,
        CMD_SR_RD,
        CMD_SR_CHK,
        CMD_SR_FRD,
        CMD_SR_FCHK,
        CMD_DECIDE,
        CMD_RK_INIT,
        CMD_RK_RDI,
        CMD_RK_LDI,
        CMD_RK_RDJ,
        CMD_RK_CHKJ,
        CMD_RK_WR,
        CMD_MG_INIT,
        CMD_MG_RD,
        CMD_MG_CHK,
        CMD_MG_END,
        CMD_SQ,
        CMD_APPEND,
        CMD_RESULT
    } t_cmd;

    typedef struct packed {
        logic range_bad;
        logic is_write;
        logic fill_zero;
        logic cs_match;
        logic cs_last;
        logic stored_zero;
        logic sr_last;
        logic sr_lo_end;
        logic dec_full;
        logic dec_hit;
        logic dec_merge;
        logic rk_jlast;
        logic rk_ilast;
        logic mg_done;
        logic sq_done;
    } t_stat;

    function automatic logic is_nz(input logic [VAL_W-1:0] v);
        return (v & ABS_MASK) != '0;
    endfunction

endpackage

/* hdl/svs_if.sv */
interface svs_in_if import svs_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [COLUMN_BITS-1:0] column;
    logic [VAL_W-1:0]       write_value;
    modport source (output valid, opcode, column, write_value, input ready);
    modport sink   (input valid, opcode, column, write_value, output ready);
endinterface

interface svs_out_if import svs_pkg::*;;
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  read_value;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  nonzero_count;
    modport source (output valid, read_value, status, nonzero_count, input ready);
    modport sink   (input valid, read_value, status, nonzero_count, output ready);
endinterface

interface svs_cfg_if import svs_pkg::*;;
    logic              valid;
    logic              ready;
    logic [VLEN_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* hdl/svs_ram.sv */
module svs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hdl/svs_ctrl.sv */
module svs_ctrl import svs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_RANGE, S_CS_RD, S_CS_CHK, S_SR_INIT, S_SR_RD, S_SR_CHK,
        S_SR_FRD, S_SR_FCHK, S_DECIDE, S_RK_INIT, S_RK_RDI, S_RK_LDI,
        S_RK_RDJ, S_RK_CHKJ, S_RK_WR, S_MG_INIT, S_MG_RD, S_MG_CHK,
        S_MG_END, S_SQ, S_APPEND, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        case (r_state)
            S_IDLE:    o_cmd = i_in_valid ? CMD_LOAD : CMD_NONE;
            S_CS_RD:   o_cmd = CMD_CS_RD;
            S_CS_CHK:  o_cmd = CMD_CS_CHK;
            S_SR_INIT: o_cmd = CMD_SR_INIT;
            S_SR_RD:   o_cmd = CMD_SR_RD;
            S_SR_CHK:  o_cmd = CMD_SR_CHK;
            S_SR_FRD:  o_cmd = CMD_SR_FRD;
            S_SR_FCHK: o_cmd = CMD_SR_FCHK;
            S_DECIDE:  o_cmd = CMD_DECIDE;
            S_RK_INIT: o_cmd = CMD_RK_INIT;
            S_RK_RDI:  o_cmd = CMD_RK_RDI;
            S_RK_LDI:  o_cmd = CMD_RK_LDI;
            S_RK_RDJ:  o_cmd = CMD_RK_RDJ;
            S_RK_CHKJ: o_cmd = CMD_RK_CHKJ;
            S_RK_WR:   o_cmd = CMD_RK_WR;
            S_MG_INIT: o_cmd = CMD_MG_INIT;
            S_MG_RD:   o_cmd = CMD_MG_RD;
            S_MG_CHK:  o_cmd = CMD_MG_CHK;
            S_MG_END:  o_cmd = CMD_MG_END;
            S_SQ:      o_cmd = CMD_SQ;
            S_APPEND:  o_cmd = CMD_APPEND;
            S_OUT:     o_cmd = out_free ? CMD_RESULT : CMD_NONE;
            default:   o_cmd = CMD_NONE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_RANGE;
            S_RANGE: begin
                if (i_stat.range_bad)      n_state = S_OUT;
                else if (i_stat.fill_zero) n_state = S_SR_INIT;
                else                       n_state = S_CS_RD;
            end
            S_CS_RD:   n_state = S_CS_CHK;
            S_CS_CHK: begin
                if (i_stat.cs_match)     n_state = S_DECIDE;
                else if (i_stat.cs_last) n_state = S_SR_INIT;
                else                     n_state = S_CS_RD;
            end
            S_SR_INIT: n_state = i_stat.stored_zero ? S_DECIDE : S_SR_RD;
            S_SR_RD:   n_state = S_SR_CHK;
            S_SR_CHK:  n_state = i_stat.sr_last ? S_SR_FRD : S_SR_RD;
            S_SR_FRD:  n_state = i_stat.sr_lo_end ? S_DECIDE : S_SR_FCHK;
            S_SR_FCHK: n_state = S_DECIDE;
            S_DECIDE: begin
                if (!i_stat.is_write || i_stat.dec_full || i_stat.dec_hit) n_state = S_OUT;
                else if (i_stat.dec_merge) n_state = S_RK_INIT;
                else                       n_state = S_APPEND;
            end
            S_RK_INIT: n_state = S_RK_RDI;
            S_RK_RDI:  n_state = S_RK_LDI;
            S_RK_LDI:  n_state = S_RK_RDJ;
            S_RK_RDJ:  n_state = S_RK_CHKJ;
            S_RK_CHKJ: n_state = i_stat.rk_jlast ? S_RK_WR : S_RK_RDJ;
            S_RK_WR:   n_state = i_stat.rk_ilast ? S_MG_INIT : S_RK_RDI;
            S_MG_INIT: n_state = S_MG_RD;
            S_MG_RD:   n_state = S_MG_CHK;
            S_MG_CHK:  n_state = i_stat.mg_done ? S_MG_END : S_MG_RD;
            S_MG_END:  n_state = S_SQ;
            S_SQ:      if (i_stat.sq_done) n_state = S_APPEND;
            S_APPEND:  n_state = S_OUT;
            S_OUT:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule

/* hdl/svs_datapath.sv */
module svs_datapath import svs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic                   i_in_op,
    input  logic [COLUMN_BITS-1:0] i_in_col,
    input  logic [VAL_W-1:0]       i_in_val,
    input  logic                   i_cfg_we,
    input  logic [VLEN_W-1:0]      i_cfg_data,
    output t_stat                  o_stat,
    output logic [VAL_W-1:0]       o_read_value,
    output logic [STAT_W-1:0]      o_status,
    output logic [CNT_W-1:0]       o_count
);
    // Control state.
    logic [VLEN_W-1:0] r_vlen;
    logic [CNT_W-1:0]  r_stored, r_total;
    logic [FILL_W-1:0] r_fill, r_limit;
    logic              r_bank;

    // Working registers of one access.
    logic                   r_op, r_hit, r_full;
    logic [COLUMN_BITS-1:0] r_col, r_rcol;
    logic [VAL_W-1:0]       r_wv, r_old_val, r_sval, r_rval;
    logic [CIDX_W-1:0]      r_hit_idx, r_rank;
    logic [FILL_W-1:0]      r_ci, r_ri, r_rj, r_root;
    logic [CNT_W-1:0]       r_lo, r_hi, r_msi, r_mni;
    logic [FILL_W-1:0]      r_mci;
    logic [VAL_W-1:0]       r_out_val;
    logic [STAT_W-1:0]      r_out_status;
    logic [CNT_W-1:0]       r_out_count;

    logic [ENTRY_W-1:0] cache_rd, csort_rd, a_rd, b_rd, store_rd;
    logic [CIDX_W-1:0]  cache_raddr, cache_waddr;
    logic [ADDR_W-1:0]  store_raddr;
    logic               cache_we, store_we;

    logic [COLUMN_BITS-1:0] c_col, s_col, k_col, m_col;
    logic [VAL_W-1:0]       c_val, s_val, k_val, m_val, old_val;
    logic [CNT_W-1:0]       mid, lo_n, hi_n, total_upd, msi_n;
    logic [FILL_W-1:0]      mci_n;
    logic                   gt, range_bad, dec_full, c_av, s_av, take_c;
    logic [FILL_W:0]        root_nxt;
    logic [SQ_W-1:0]        root_sq;
    logic                   sq_go;

    assign c_col = cache_rd[ENTRY_W-1:VAL_W];
    assign c_val = cache_rd[VAL_W-1:0];
    assign store_rd = r_bank ? b_rd : a_rd;
    assign s_col = store_rd[ENTRY_W-1:VAL_W];
    assign s_val = store_rd[VAL_W-1:0];
    assign k_col = csort_rd[ENTRY_W-1:VAL_W];
    assign k_val = csort_rd[VAL_W-1:0];

    assign range_bad = {1'b0, r_col} >= r_vlen;
    assign old_val   = r_hit ? r_old_val : r_sval;
    assign dec_full  = !is_nz(old_val) && is_nz(r_wv) && (r_total >= CNT_W'(MAX_NONZERO));
    // Each cached entry counts nz(cached) - found_in_store, so the total moves by the
    // change of nonzero-ness of the written column.
    assign total_upd = r_total + CNT_W'(is_nz(r_wv)) - CNT_W'(is_nz(old_val));

    assign mid  = r_lo + ((r_hi - r_lo) >> 1);
    assign gt   = r_col > s_col;
    assign lo_n = gt ? mid + CNT_W'(1) : r_lo;
    assign hi_n = gt ? r_hi : mid;

    assign c_av   = r_mci < r_fill;
    assign s_av   = r_msi < r_stored;
    assign take_c = c_av && (!s_av || k_col <= s_col);
    assign m_col  = take_c ? k_col : s_col;
    assign m_val  = take_c ? k_val : s_val;
    assign mci_n  = take_c ? r_mci + FILL_W'(1) : r_mci;
    assign msi_n  = (!take_c || (s_av && k_col == s_col)) ? r_msi + CNT_W'(1) : r_msi;

    assign root_nxt = {1'b0, r_root} + (FILL_W + 1)'(1);
    assign root_sq  = SQ_W'(root_nxt) * SQ_W'(root_nxt);
    assign sq_go    = (root_sq <= SQ_W'(r_stored)) && (r_root < FILL_W'(CACHE_DEPTH));

    always_comb begin
        case (i_cmd)
            CMD_CS_RD:  cache_raddr = CIDX_W'(r_ci - FILL_W'(1));
            CMD_RK_RDI: cache_raddr = r_ri[CIDX_W-1:0];
            CMD_RK_RDJ: cache_raddr = r_rj[CIDX_W-1:0];
            default:    cache_raddr = '0;
        endcase
        case (i_cmd)
            CMD_SR_RD:  store_raddr = mid[ADDR_W-1:0];
            CMD_SR_FRD: store_raddr = r_lo[ADDR_W-1:0];
            CMD_MG_RD:  store_raddr = r_msi[ADDR_W-1:0];
            default:    store_raddr = '0;
        endcase
    end

    assign cache_we = (i_cmd == CMD_APPEND)
                   || (i_cmd == CMD_DECIDE && r_op == OP_WRITE && r_hit && !dec_full);
    assign cache_waddr = (i_cmd == CMD_APPEND) ? r_fill[CIDX_W-1:0] : r_hit_idx;
    assign store_we = (i_cmd == CMD_MG_CHK) && is_nz(m_val);

    svs_ram #(.WIDTH(ENTRY_W), .DEPTH(CACHE_DEPTH)) u_cache (
        .i_clk(i_clk), .i_we(cache_we), .i_waddr(cache_waddr),
        .i_wdata({r_col, r_wv}), .i_raddr(cache_raddr), .o_rdata(cache_rd));

    svs_ram #(.WIDTH(ENTRY_W), .DEPTH(CACHE_DEPTH)) u_csort (
        .i_clk(i_clk), .i_we(i_cmd == CMD_RK_WR), .i_waddr(r_rank),
        .i_wdata({r_rcol, r_rval}), .i_raddr(r_mci[CIDX_W-1:0]), .o_rdata(csort_rd));

    svs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NONZERO)) u_store_a (
        .i_clk(i_clk), .i_we(store_we && r_bank), .i_waddr(r_mni[ADDR_W-1:0]),
        .i_wdata({m_col, m_val}), .i_raddr(store_raddr), .o_rdata(a_rd));

    svs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NONZERO)) u_store_b (
        .i_clk(i_clk), .i_we(store_we && !r_bank), .i_waddr(r_mni[ADDR_W-1:0]),
        .i_wdata({m_col, m_val}), .i_raddr(store_raddr), .o_rdata(b_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen   <= VLEN_W'(1) << COLUMN_BITS;
            r_stored <= '0;
            r_total  <= '0;
            r_fill   <= '0;
            r_limit  <= FILL_W'(1);
            r_bank   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vlen <= i_cfg_data;
            end
            case (i_cmd)
                CMD_DECIDE: begin
                    if (r_op == OP_WRITE && r_hit && !dec_full) r_total <= total_upd;
                end
                CMD_MG_END: begin
                    r_bank   <= !r_bank;
                    r_stored <= r_mni;
                    r_fill   <= '0;
                end
                CMD_SQ: begin
                    if (!sq_go) r_limit <= (r_root == '0) ? FILL_W'(1) : r_root;
                end
                CMD_APPEND: begin
                    r_fill  <= r_fill + FILL_W'(1);
                    r_total <= total_upd;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_op   <= i_in_op;
                r_col  <= i_in_col;
                r_wv   <= i_in_val;
                r_ci   <= r_fill;
                r_hit  <= 1'b0;
                r_full <= 1'b0;
                r_sval <= '0;
            end
            CMD_CS_CHK: begin
                r_ci <= r_ci - FILL_W'(1);
                if (c_col == r_col) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= CIDX_W'(r_ci - FILL_W'(1));
                    r_old_val <= c_val;
                end
            end
            CMD_SR_INIT: begin
                r_lo <= '0;
                r_hi <= r_stored;
            end
            CMD_SR_CHK: begin
                r_lo <= lo_n;
                r_hi <= hi_n;
            end
            CMD_SR_FCHK: begin
                if (s_col == r_col) r_sval <= s_val;
            end
            CMD_DECIDE: begin
                if (r_op == OP_WRITE && dec_full) r_full <= 1'b1;
            end
            CMD_RK_INIT: r_ri <= '0;
            CMD_RK_LDI: begin
                r_rcol <= c_col;
                r_rval <= c_val;
                r_rj   <= '0;
                r_rank <= '0;
            end
            CMD_RK_CHKJ: begin
                r_rj <= r_rj + FILL_W'(1);
                if (c_col < r_rcol) r_rank <= r_rank + CIDX_W'(1);
            end
            CMD_RK_WR: r_ri <= r_ri + FILL_W'(1);
            CMD_MG_INIT: begin
                r_mci <= '0;
                r_msi <= '0;
                r_mni <= '0;
            end
            CMD_MG_CHK: begin
                r_mci <= mci_n;
                r_msi <= msi_n;
                if (is_nz(m_val)) r_mni <= r_mni + CNT_W'(1);
            end
            CMD_MG_END: r_root <= '0;
            CMD_SQ: begin
                if (sq_go) r_root <= root_nxt[FILL_W-1:0];
            end
            CMD_RESULT: begin
                r_out_status <= range_bad ? ST_RANGE : (r_full ? ST_FULL : ST_OK);
                r_out_val    <= (range_bad || r_op == OP_WRITE) ? '0 : old_val;
                r_out_count  <= r_total;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.range_bad   = range_bad;
        o_stat.is_write    = (r_op == OP_WRITE);
        o_stat.fill_zero   = (r_fill == '0);
        o_stat.cs_match    = (c_col == r_col);
        o_stat.cs_last     = (r_ci == FILL_W'(1));
        o_stat.stored_zero = (r_stored == '0);
        o_stat.sr_last     = (lo_n >= hi_n);
        o_stat.sr_lo_end   = (r_lo >= r_stored);
        o_stat.dec_full    = dec_full;
        o_stat.dec_hit     = r_hit;
        o_stat.dec_merge   = (r_fill >= r_limit);
        o_stat.rk_jlast    = (r_rj + FILL_W'(1) == r_fill);
        o_stat.rk_ilast    = (r_ri + FILL_W'(1) == r_fill);
        o_stat.mg_done     = (mci_n >= r_fill) && (msi_n >= r_stored);
        o_stat.sq_done     = !sq_go;
    end

    assign o_read_value = r_out_val;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;
endmodule

/* hdl/sparse_vector_store.sv */
// Sparse vector store: a sorted column/value store with a small unsorted write cache.
// The input channel i_in takes one access per transfer: a read (opcode 0) or a write
// (opcode 1) of a raw 64-bit double at a column. Each access produces exactly one
// transfer on o_out carrying the value read, a status code and the nonzero count.
// The configuration channel i_cfg sets the vector length; it is always ready and
// should only be written while no access is in flight.
// One access is processed at a time. A read scans the cache newest first and,
// when no cached entry matches, then binary-searches the store, which holds up to
// 1024 entries beside a 32-entry cache. A write that triggers a flush additionally
// ranks the cache, merges it into the other store bank and recomputes the cache
// length by stepping up an integer square root of the stored count.
// Reset empties the store and the cache and restores the full vector length; no
// clearing sweep is needed. When the receiver stalls, the finished result waits in
// the output register and the next access is held until that result can be loaded.
module sparse_vector_store import svs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    svs_in_if.sink   i_in,
    svs_cfg_if.sink  i_cfg,
    svs_out_if.source o_out
);
    t_cmd  cmd;
    t_stat stat;

    // Configuration writes land directly in the length register.
    assign i_cfg.ready = 1'b1;

    svs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    svs_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_in_op      (i_in.opcode),
        .i_in_col     (i_in.column),
        .i_in_val     (i_in.write_value),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .o_stat       (stat),
        .o_read_value (o_out.read_value),
        .o_status     (o_out.status),
        .o_count      (o_out.nonzero_count)
    );

    // Once an access is taken, no other is taken until its result is produced.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while an access is in flight");

    // The count never exceeds the store capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.nonzero_count <= CNT_W'(MAX_NONZERO)))
        else $error("nonzero count above capacity");

    // Rejected accesses never return data (writes return none either, but only rejections are checked here).
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_RANGE || o_out.status == ST_FULL))
        |-> (o_out.read_value == '0))
        else $error("rejected access returned data");

    // A store-full result is only produced while the store is at capacity.
    a_full_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_FULL)
        |-> (o_out.nonzero_count == CNT_W'(MAX_NONZERO)))
        else $error("store-full status below capacity");
endmodule

/* tb/sv/tb_sparse_vector_store.sv */
module tb_sparse_vector_store;
    timeunit 1ns;
    timeprecision 1ps;

    import svs_pkg::*;

    // The access, register write and result channels of the block.
    logic i_clk;
    logic i_rst_n;

    svs_in_if  in_ch ();
    svs_out_if out_ch ();
    svs_cfg_if cfg_ch ();

    sparse_vector_store dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_out  (out_ch.source)
    );

    // One access as the driver offers it.
    typedef struct {
        logic                   opcode;
        logic [COLUMN_BITS-1:0] column;
        logic [VAL_W-1:0]       write_value;
    } t_access;

    // One result as the block should return it.
    typedef struct {
        logic [VAL_W-1:0]  read_value;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  nonzero_count;
    } t_answer;

    t_access pending_access[$];
    t_answer expected_answers[$];
    int      error_count = 0;
    int      accepted_count = 0;
    int      queued_count = 0;

    // The shadow copy of the vector that the expected answers are computed from.
    logic [COLUMN_BITS-1:0] shadow_cols[MAX_NONZERO];
    logic [VAL_W-1:0]       shadow_vals[MAX_NONZERO];
    int                     shadow_count;
    logic [COLUMN_BITS-1:0] pend_cols[CACHE_DEPTH];
    logic [VAL_W-1:0]       pend_vals[CACHE_DEPTH];
    int                     pend_fill;
    int                     pend_limit;
    logic [VLEN_W-1:0]      shadow_length;

    // The receiver holds off for this many cycles when it is nonzero.
    int long_hold = 0;

    function automatic bit value_nonzero(logic [VAL_W-1:0] v);
        return (v & ABS_MASK) != '0;
    endfunction

    function automatic bit pend_lookup(logic [COLUMN_BITS-1:0] c, output int idx);
        for (int i = pend_fill - 1; i >= 0; i--) begin
            if (pend_cols[i] == c) begin
                idx = i;
                return 1;
            end
        end
        idx = 0;
        return 0;
    endfunction

    function automatic bit shadow_lookup(logic [COLUMN_BITS-1:0] c,
                                         output logic [VAL_W-1:0] v);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (c > shadow_cols[mid]) lo = mid + 1;
            else hi = mid;
        end
        if (lo < shadow_count && shadow_cols[lo] == c) begin
            v = shadow_vals[lo];
            return 1;
        end
        v = '0;
        return 0;
    endfunction

    // Nonzero entries as if the cache were already folded into the store.
    function automatic int live_count();
        int n;
        bit found;
        bit nz;
        logic [VAL_W-1:0] sv;
        n = shadow_count;
        for (int i = 0; i < pend_fill; i++) begin
            found = shadow_lookup(pend_cols[i], sv);
            nz = value_nonzero(pend_vals[i]);
            if (!found && nz) n++;
            else if (found && !nz && n > 0) n--;
        end
        return n;
    endfunction

    // Sort the cache, fold it into the store, drop zero entries and recompute the cache limit.
    function automatic void fold_cache();
        logic [COLUMN_BITS-1:0] mc[MAX_NONZERO];
        logic [VAL_W-1:0]       mv[MAX_NONZERO];
        logic [COLUMN_BITS-1:0] c;
        logic [VAL_W-1:0]       v;
        int ci;
        int si;
        int ni;
        int j;
        int r;
        ci = 0;
        si = 0;
        ni = 0;
        if (pend_fill == 0) return;
        for (int i = 1; i < pend_fill; i++) begin
            c = pend_cols[i];
            v = pend_vals[i];
            j = i;
            while (j > 0 && pend_cols[j-1] > c) begin
                pend_cols[j] = pend_cols[j-1];
                pend_vals[j] = pend_vals[j-1];
                j--;
            end
            pend_cols[j] = c;
            pend_vals[j] = v;
        end
        while (ci < pend_fill || si < shadow_count) begin
            if (ci < pend_fill && (si >= shadow_count || pend_cols[ci] <= shadow_cols[si])) begin
                if (si < shadow_count && pend_cols[ci] == shadow_cols[si]) si++;
                c = pend_cols[ci];
                v = pend_vals[ci];
                ci++;
            end else begin
                c = shadow_cols[si];
                v = shadow_vals[si];
                si++;
            end
            if (value_nonzero(v) && ni < MAX_NONZERO) begin
                mc[ni] = c;
                mv[ni] = v;
                ni++;
            end
        end
        for (int i = 0; i < ni; i++) begin
            shadow_cols[i] = mc[i];
            shadow_vals[i] = mv[i];
        end
        shadow_count = ni;
        pend_fill = 0;
        r = 0;
        while ((r + 1) * (r + 1) <= ni) r++;
        if (r < 1) r = 1;
        if (r > CACHE_DEPTH) r = CACHE_DEPTH;
        pend_limit = r;
    endfunction

    // Apply one access to the shadow vector and return what the block must answer.
    function automatic t_answer predict_access(t_access a);
        t_answer ans;
        int idx;
        bit in_pend;
        logic [VAL_W-1:0] old;
        ans.read_value = '0;
        ans.status = ST_OK;
        if ({1'b0, a.column} >= shadow_length) begin
            ans.status = ST_RANGE;
        end else if (a.opcode == OP_READ) begin
            if (pend_lookup(a.column, idx)) ans.read_value = pend_vals[idx];
            else void'(shadow_lookup(a.column, ans.read_value));
        end else begin
            in_pend = pend_lookup(a.column, idx);
            if (in_pend) old = pend_vals[idx];
            else void'(shadow_lookup(a.column, old));
            if (!value_nonzero(old) && value_nonzero(a.write_value)
                    && live_count() >= MAX_NONZERO) begin
                ans.status = ST_FULL;
            end else if (in_pend) begin
                pend_vals[idx] = a.write_value;
            end else begin
                if (pend_fill >= pend_limit || pend_fill >= CACHE_DEPTH) fold_cache();
                if (pend_fill < CACHE_DEPTH) begin
                    pend_cols[pend_fill] = a.column;
                    pend_vals[pend_fill] = a.write_value;
                    pend_fill++;
                end
            end
        end
        ans.nonzero_count = CNT_W'(live_count());
        return ans;
    endfunction

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The driver offers one access after a random gap and holds it until the
    // transfer happens.
    int send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap <= $urandom_range(0, 17);
        end else if (in_ch.valid && !in_ch.ready) begin
            // Hold the offer until the block takes it.
        end else begin
            if (in_ch.valid) begin
                expected_answers.push_back(predict_access('{in_ch.opcode, in_ch.column,
                                                            in_ch.write_value}));
                accepted_count <= accepted_count + 1;
            end
            if (send_gap > 0 || pending_access.size() == 0) begin
                in_ch.valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                t_access a;
                a = pending_access.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.opcode <= a.opcode;
                in_ch.column <= a.column;
                in_ch.write_value <= a.write_value;
                // Long runs without gaps are as useful as random gaps.
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            end
        end
    end

    // The monitor checks each result transfer against the oldest expectation
    // and then stalls the output for a random number of cycles.
    int recv_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result read_value=%h status=%0d count=%0d",
                             $time, out_ch.read_value, out_ch.status, out_ch.nonzero_count);
                    error_count++;
                end else begin
                    t_answer e;
                    e = expected_answers.pop_front();
                    if (out_ch.read_value !== e.read_value) begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, e.read_value, out_ch.read_value);
                        error_count++;
                    end
                    if (out_ch.status !== e.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, out_ch.status);
                        error_count++;
                    end
                    if (out_ch.nonzero_count !== e.nonzero_count) begin
                        $display("%0t: nonzero_count expected %0d actual %0d",
                                 $time, e.nonzero_count, out_ch.nonzero_count);
                        error_count++;
                    end
                end
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                out_ch.ready <= 1'b0;
            end else if (long_hold > 0) begin
                out_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // The long output stall counts down in a process of its own.
    always @(posedge i_clk) begin
        if (long_hold > 0) long_hold <= long_hold - 1;
    end

    task automatic queue_access(logic op, logic [COLUMN_BITS-1:0] col, logic [VAL_W-1:0] v);
        pending_access.push_back('{op, col, v});
        queued_count++;
    endtask

    // A random double pattern biased toward the zero cases.
    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return 64'h8000_0000_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Waits until every queued access has been transferred and answered, then lets
    // the block settle before the register is touched.
    task automatic drain();
        while (accepted_count < queued_count || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_length(logic [VLEN_W-1:0] len);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= len;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        shadow_length = len;
    endtask

    // Random traffic: a working set of columns in a window so that reads hit,
    // writes overwrite and the cache merges often.
    task automatic random_phase(int count, int span, int base);
        logic [COLUMN_BITS-1:0] col;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0) col = COLUMN_BITS'($urandom);
            else col = COLUMN_BITS'(base + $urandom_range(0, span - 1));
            queue_access(1'($urandom_range(0, 1)), col, random_value());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_READ;
        in_ch.column = '0;
        in_ch.write_value = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        shadow_count = 0;
        pend_fill = 0;
        pend_limit = 1;
        shadow_length = VLEN_W'(65536);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed accesses: empty reads, extremes of column and value, both
        // zeros, overwrites in the cache, merges that delete everything.
        queue_access(OP_READ, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_access(OP_READ, 16'hFFFF, 64'h0);
        queue_access(OP_WRITE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_access(OP_READ, 16'hFFFF, 64'h0);
        queue_access(OP_WRITE, 16'h0000, 64'h0000_0000_0000_0001);
        queue_access(OP_WRITE, 16'h0000, 64'h8000_0000_0000_0000);
        queue_access(OP_WRITE, 16'h1234, 64'h0);
        queue_access(OP_WRITE, 16'h0005, 64'h7FF8_0000_0000_0000);
        queue_access(OP_READ, 16'h0005, 64'h0);
        queue_access(OP_WRITE, 16'hFFFF, 64'h0);
        queue_access(OP_WRITE, 16'h0005, 64'h8000_0000_0000_0000);
        queue_access(OP_WRITE, 16'h0100, 64'h0);
        queue_access(OP_READ, 16'h0000, 64'h0);
        queue_access(OP_READ, 16'h0005, 64'h0);
        for (int i = 0; i < 6; i++)
            queue_access(OP_WRITE, 16'(i * 3), {$urandom, $urandom} | 64'h1);
        drain();

        // A short vector rejects columns at and beyond its length.
        write_length(VLEN_W'(16));
        queue_access(OP_WRITE, 16'd16, 64'h3FF0_0000_0000_0000);
        queue_access(OP_READ, 16'd16, 64'h0);
        queue_access(OP_READ, 16'd15, 64'h0);
        queue_access(OP_WRITE, 16'd15, 64'h3FF0_0000_0000_0000);
        drain();

        // A zero length rejects every access.
        write_length('0);
        queue_access(OP_READ, 16'd0, 64'h0);
        queue_access(OP_WRITE, 16'd0, 64'h1);
        random_phase(30, 64, 0);
        drain();

        write_length(VLEN_W'(300));
        random_phase(200, 320, 0);
        // Hold the output off so the block backs up onto its input.
        long_hold = 400;
        drain();

        write_length(VLEN_W'(65536));
        random_phase(200, 60, 1000);
        drain();

        // Fill the store to its limit so that the overflow status appears,
        // then keep reading and writing around the full store.
        for (int i = 0; i < MAX_NONZERO + 8; i++)
            queue_access(OP_WRITE, 16'(20000 + i * 7), {$urandom, $urandom} | 64'h1);
        random_phase(200, 8000, 20000);
        drain();

        write_length(VLEN_W'(40000));
        random_phase(250, 1000, 39500);
        drain();

        write_length(VLEN_W'(65535));
        random_phase(150, 200, 65336);
        drain();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
